// File: rtl/cms_pkg.sv
// Shared types and constants for the compacting member set.
// No dependencies; imported by cms_cell, compacting_member_set_top, cms_checker and tb.
package cms_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int POS_W    = 5;
  localparam int OCNT_W   = 5;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_LOOKUP = 3'd2,
    CMD_READ   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Broadcast from the control section to every cell.
  typedef struct packed {
    logic             ins_en;
    logic             rem_cmd;
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] position;
  } cell_ctrl_t;

endpackage

// File: rtl/compacting_member_set_top.sv
// Compacting member set: command decode, count and result register around a
// chain of cms_cell slots. Depends on cms_pkg and cms_cell.
// Latency: a word accepted at one edge is compared and applied by the cell
//   chain in the next cycle; its result strobes for one cycle after that.
// Flow: no new command is taken while the command register feeds the
//   compare-and-shift pass of the cell chain; busy is high during that pass.
// Reset: count clears, busy and out_strobe drop; slot words are not cleared.
module compacting_member_set_top import cms_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [DATA_W-1:0] in_value,
  input  logic [POS_W-1:0]  in_position,
  output logic              out_strobe,
  output logic              out_hit,
  output logic [DATA_W-1:0] out_read_data,
  output logic [OCNT_W-1:0] out_count,
  output logic [STAT_W-1:0] out_status
);

  logic              pend_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [DATA_W-1:0] value_r;
  logic [POS_W-1:0]  pos_r;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              strobe_r;
  logic              hit_r, hit_nxt;
  logic [DATA_W-1:0] rdata_r, rdata_nxt;
  logic [OCNT_W-1:0] ocount_r;
  logic [STAT_W-1:0] status_r, status_nxt;

  cell_ctrl_t        ctrl;
  logic [CAPACITY:0] prefix;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_rd   [CAPACITY];
  logic [DATA_W-1:0] rd_or;
  logic              hit;
  logic              room;
  logic              pos_ok;

  logic accept;
  assign accept = start && !busy;
  assign busy   = pend_r;

  assign hit    = prefix[CAPACITY];
  assign room   = count_r < CNT_W'(CAPACITY);
  assign pos_ok = (pos_r != '0) && (CMP_W'(pos_r) <= CMP_W'(count_r))
                  && (CMP_W'(pos_r) <= CMP_W'(CAPACITY));

  assign ctrl.ins_en   = pend_r && (cmd_r == CMD_INSERT) && !hit && room;
  assign ctrl.rem_cmd  = pend_r && (cmd_r == CMD_REMOVE);
  assign ctrl.count    = count_r;
  assign ctrl.position = pos_r;

  assign prefix[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] nbr;
    if (i == CAPACITY - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end
    cms_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .ctrl       (ctrl),
      .value      (value_r),
      .nbr_data   (nbr),
      .prefix_in  (prefix[i]),
      .prefix_out (prefix[i+1]),
      .data       (cell_data[i]),
      .rd_data    (cell_rd[i])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  always_comb begin
    count_nxt  = count_r;
    hit_nxt    = 1'b0;
    rdata_nxt  = '0;
    status_nxt = ST_OK;
    case (cmd_r)
      CMD_INSERT: begin
        hit_nxt = hit;
        if (!hit) begin
          if (room) count_nxt = count_r + CNT_W'(1);
          else      status_nxt = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        hit_nxt = hit;
        if (hit) count_nxt = count_r - CNT_W'(1);
      end
      CMD_LOOKUP: begin
        hit_nxt = hit;
      end
      CMD_READ: begin
        if (pos_ok) rdata_nxt  = rd_or;
        else        status_nxt = ST_RANGE;
      end
      CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 1'b0;
      strobe_r <= 1'b0;
      count_r  <= '0;
    end else begin
      pend_r   <= accept;
      strobe_r <= pend_r;
      if (pend_r) count_r <= count_nxt;
    end
  end

  // Hold the command word and the result word; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      value_r <= in_value;
      pos_r   <= in_position;
    end
    if (pend_r) begin
      hit_r    <= hit_nxt;
      rdata_r  <= rdata_nxt;
      ocount_r <= OCNT_W'(count_nxt);
      status_r <= status_nxt;
    end
  end

  assign out_strobe    = strobe_r;
  assign out_hit       = hit_r;
  assign out_read_data = rdata_r;
  assign out_count     = ocount_r;
  assign out_status    = status_r;

endmodule

// File: rtl/cms_cell.sv
// One slot of the set: holds a member word, compares it against the command word,
// takes that word on an insert and its right neighbor's word on a remove. Depends on cms_pkg.
module cms_cell import cms_pkg::*; (
  input  logic              clk,
  input  logic [IDX_W-1:0]  idx,
  input  cell_ctrl_t        ctrl,
  input  logic [DATA_W-1:0] value,
  input  logic [DATA_W-1:0] nbr_data,
  input  logic              prefix_in,
  output logic              prefix_out,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic [CNT_W-1:0]  idx_c;
  logic [CNT_W-1:0]  idx_p1;
  logic [CMP_W-1:0]  idx_p1_w;
  logic              live;
  logic              match;

  assign idx_c    = CNT_W'(idx);
  assign idx_p1   = idx_c + CNT_W'(1);
  assign idx_p1_w = CMP_W'(idx_p1);
  assign live     = idx_c < ctrl.count;
  assign match    = live && (data_r == value);

  // Marks this slot and every later one once the command word is found.
  assign prefix_out = prefix_in | match;

  assign data    = data_r;
  assign rd_data = (idx_p1_w == CMP_W'(ctrl.position)) ? data_r : '0;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins_en && (idx_c == ctrl.count)) begin
      data_nxt = value;
    end else if (ctrl.rem_cmd && prefix_out && (idx_p1 < ctrl.count)) begin
      data_nxt = nbr_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// File: verif/cms_checker.sv
// Result checker for the compacting member set: tracks accepted command words,
// predicts each result from its own copy of the set and compares it field by field.
// Depends on cms_pkg.
`timescale 1ns / 100ps

module cms_checker import cms_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [DATA_W-1:0] in_value,
  input  logic [POS_W-1:0]  in_position,
  input  logic              out_strobe,
  input  logic              out_hit,
  input  logic [DATA_W-1:0] out_read_data,
  input  logic [OCNT_W-1:0] out_count,
  input  logic [STAT_W-1:0] out_status,
  output int                fail_count,
  output int                pending,
  output int                checked,
  output int                hits,
  output int                fulls,
  output int                ranges
);

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_data;
    logic [OCNT_W-1:0] count;
    status_t           status;
  } set_result_t;

  logic [DATA_W-1:0] members [CAPACITY];
  int unsigned       member_total;
  set_result_t       expected_results [$];

  // Apply one command to the shadow set and return the result it should give.
  task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
                               input logic [POS_W-1:0] pos, output set_result_t res);
    int unsigned slot;
    logic        present;
    slot = member_total;
    for (int i = 0; i < member_total; i++)
      if (members[i] == value && slot == member_total) slot = i;
    present = (slot < member_total);
    res = '{hit: 1'b0, read_data: '0, count: '0, status: ST_OK};
    case (cmd)
      CMD_INSERT: begin
        res.hit = present;
        if (!present) begin
          if (member_total >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            members[member_total] = value;
            member_total++;
          end
        end
      end
      CMD_REMOVE: begin
        res.hit = present;
        // close the gap left by the removed word
        if (present) begin
          for (int j = slot; j + 1 < member_total; j++) members[j] = members[j+1];
          member_total--;
        end
      end
      CMD_LOOKUP: res.hit = present;
      CMD_READ: begin
        if (pos >= 1 && pos <= member_total) res.read_data = members[pos-1];
        else res.status = ST_RANGE;
      end
      CMD_CLEAR: member_total = 0;
      default: ;
    endcase
    res.count = OCNT_W'(member_total);
  endtask

  always @(posedge clk) begin
    set_result_t want;
    set_result_t got;
    if (!rst_n) begin
      member_total = 0;
      expected_results.delete();
      fail_count = 0;
      checked = 0;
      hits = 0;
      fulls = 0;
      ranges = 0;
    end else begin
      if (out_strobe) begin
        got = '{hit: out_hit, read_data: out_read_data, count: out_count,
                status: status_t'(out_status)};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%t: result word with none expected: hit=%0b data=%h count=%0d st=%0d",
                     $realtime, out_hit, out_read_data, out_count, out_status);
        end else begin
          want = expected_results.pop_front();
          checked++;
          hits += want.hit;
          if (want.status == ST_FULL) fulls++;
          if (want.status == ST_RANGE) ranges++;
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%t: result %0d: hit %0b/%0b data %h/%h count %0d/%0d st %0d/%0d (exp/act)",
                       $realtime, checked, want.hit, got.hit, want.read_data, got.read_data,
                       want.count, got.count, want.status, got.status);
          end
        end
      end
      if (start && !busy) begin
        apply_command(in_cmd, in_value, in_position, want);
        expected_results.push_back(want);
      end
    end
    pending = expected_results.size();
  end

endmodule

// File: verif/tb.sv
// Testbench top for compacting_member_set_top: clock, reset and command stimulus,
// with cms_checker alongside the block. Depends on cms_pkg and cms_checker.
`timescale 1ns / 100ps

module tb;
  import cms_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
  localparam int RANDOM_WORDS = 1900;
  localparam int POOL_SIZE = 24;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [CMD_W-1:0]  in_cmd = '0;
  logic [DATA_W-1:0] in_value = '0;
  logic [POS_W-1:0]  in_position = '0;
  logic              out_strobe;
  logic              out_hit;
  logic [DATA_W-1:0] out_read_data;
  logic [OCNT_W-1:0] out_count;
  logic [STAT_W-1:0] out_status;

  int fail_count, pending, checked, hits, fulls, ranges;
  int words_sent = 0;
  logic [DATA_W-1:0] value_pool [POOL_SIZE];

  always #10 clk = ~clk;

  compacting_member_set_top u_dut (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_value, .in_position,
    .out_strobe, .out_hit, .out_read_data, .out_count, .out_status
  );

  cms_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_value, .in_position,
    .out_strobe, .out_hit, .out_read_data, .out_count, .out_status,
    .fail_count, .pending, .checked, .hits, .fulls, .ranges
  );

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
                           input logic [POS_W-1:0] pos, input bit may_idle);
    if (may_idle)
      while ($urandom_range(0, 99) < 6) begin
        start = 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
    start = 1'b1;
    in_cmd = cmd;
    in_value = value;
    in_position = pos;
    while (busy) @(negedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Hold off until every outstanding result word has come back.
  task automatic drain_results();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 85) return value_pool[$urandom_range(0, POOL_SIZE-1)];
    return $urandom;
  endfunction

  initial begin
    int r;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) value_pool[i] = $urandom;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty set, extremes, duplicates, full, range edges, compaction
    send_word(CMD_READ, '0, 5'd0, 0);
    send_word(CMD_REMOVE, 32'h1234_5678, 5'd0, 0);
    send_word(CMD_INSERT, 32'h0000_0000, 5'd0, 0);
    send_word(CMD_INSERT, 32'hFFFF_FFFF, 5'd31, 0);
    send_word(CMD_INSERT, 32'h0000_0000, 5'd0, 0);
    send_word(CMD_LOOKUP, 32'hFFFF_FFFF, 5'd0, 0);
    send_word(CMD_READ, '0, 5'd2, 0);
    send_word(CMD_READ, '0, 5'd3, 0);
    for (int i = 0; i < CAPACITY - 2; i++)
      send_word(CMD_INSERT, 32'hA5A5_0000 + i, 5'd0, 0);
    send_word(CMD_INSERT, 32'h5A5A_5A5A, 5'd0, 0);
    send_word(CMD_READ, '0, 5'd16, 0);
    send_word(CMD_READ, '0, 5'd17, 0);
    send_word(CMD_REMOVE, 32'hA5A5_0005, 5'd0, 0);
    send_word(CMD_REMOVE, 32'h0000_0000, 5'd0, 0);
    send_word(CMD_REMOVE, 32'hA5A5_000D, 5'd0, 0);
    send_word(CMD_UNUSED_LO, 32'hFFFF_FFFF, 5'd31, 0);
    send_word(CMD_UNUSED_HI, 32'h0000_0000, 5'd1, 0);
    send_word(CMD_CLEAR, '0, 5'd0, 0);
    drain_results();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) drain_results();
      r = $urandom_range(0, 99);
      pos = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 17));
      if (r < 40) cmd = CMD_INSERT;
      else if (r < 60) cmd = CMD_REMOVE;
      else if (r < 74) cmd = CMD_LOOKUP;
      else if (r < 92) cmd = CMD_READ;
      else if (r < 93) cmd = CMD_CLEAR;
      else if (r < 96) cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      else cmd = CMD_INSERT;
      // keep a long stretch back to back
      send_word(cmd, pick_value(), pos, !(i >= 700 && i < 1100));
    end

    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Ran %0d command words, %0d results checked, %0d mismatches.",
             words_sent, checked, fail_count);
    $display("Results covered %0d hits, %0d full refusals, %0d out-of-range reads.",
             hits, fulls, ranges);
    if (fail_count == 0 && pending == 0) begin
      $display("compacting_member_set_top: match");
    end else begin
      $display("compacting_member_set_top: mismatch");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out with %0d results outstanding.", pending);
    $display("compacting_member_set_top: mismatch");
    $finish;
  end

endmodule

// File: filelist.f
rtl/cms_pkg.sv
rtl/cms_cell.sv
rtl/compacting_member_set_top.sv
verif/cms_checker.sv
verif/tb.sv
